>>> src/dirty_rect_tracker_defines.svh
// Assertion macros used by the dirty rectangle tracker top level.
`ifndef DIRTY_RECT_TRACKER_DEFINES_SVH
`define DIRTY_RECT_TRACKER_DEFINES_SVH
`ifndef SYNTHESIS
`define DRT_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dirty rectangle tracker check failed");
`define DRT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dirty rectangle tracker check failed");
`else
`define DRT_ASSERT_IMP(lbl, ante, cons)
`define DRT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> src/drt_pkg.sv
// Types and constants shared by the dirty rectangle tracker.
package drt_pkg;
   localparam int MAX_RECTS       = 128;
   localparam int COORD_BITS      = 16;
   localparam int MAX_RECTS_LIMIT = 1024;
   localparam int REM_W           = $clog2(MAX_RECTS_LIMIT + 1);
   localparam int RADIUS_W        = 8;
   localparam int POS_W           = 16;
   localparam int SIZE_W          = 15;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 16;
   localparam int ENTRY_COUNT_W   = 8;
   localparam int UNION_SIZE_W    = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RADIUS   = 3'd0,
      CSR_BOUNDS_X = 3'd1,
      CSR_BOUNDS_Y = 3'd2,
      CSR_BOUNDS_W = 3'd3,
      CSR_BOUNDS_H = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_CLIP,
      ST_SCAN_CHECK,
      ST_SCAN_UPDATE,
      ST_FINISH
   } state_type;

   typedef enum logic {
      OP_CHECK,
      OP_UPDATE
   } scan_op_type;

   typedef enum logic {
      MODE_MARK  = 1'b0,
      MODE_CLEAR = 1'b1
   } mode_type;

   typedef struct packed {
      logic             found;
      logic             pending;
      logic [REM_W-1:0] nrem;
   } carry_type;
endpackage

>>> src/drt_req_if.sv
// Request channel carrying one rectangle item.
interface drt_req_if import drt_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic                     mode;
   logic signed [POS_W-1:0]  rect_x;
   logic signed [POS_W-1:0]  rect_y;
   logic        [SIZE_W-1:0] rect_w;
   logic        [SIZE_W-1:0] rect_h;
   modport source(output valid, mode, rect_x, rect_y, rect_w, rect_h, input ready);
   modport sink(input valid, mode, rect_x, rect_y, rect_w, rect_h, output ready);
endinterface

>>> src/drt_rsp_if.sv
// Response channel carrying one table summary item.
interface drt_rsp_if import drt_pkg::*;;
   logic                           valid;
   logic                           ready;
   logic                           is_dirty;
   logic        [ENTRY_COUNT_W-1:0] entry_count;
   logic signed [POS_W-1:0]        union_x;
   logic signed [POS_W-1:0]        union_y;
   logic        [UNION_SIZE_W-1:0] union_w;
   logic        [UNION_SIZE_W-1:0] union_h;
   logic                           overflowed;
   modport source(output valid, is_dirty, entry_count, union_x, union_y, union_w, union_h,
                  overflowed, input ready);
   modport sink(input valid, is_dirty, entry_count, union_x, union_y, union_w, union_h,
                overflowed, output ready);
endinterface

>>> src/drt_cell.sv
// One table slot of the rectangle chain with its registered scan token and carry.
module drt_cell import drt_pkg::*; #(
   parameter int WB = 19
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            clr,
   input  scan_op_type     op,
   input  logic [4*WB-1:0] nbox,
   input  logic            tok_in,
   input  carry_type       carry_in,
   output logic            tok_out,
   output carry_type       carry_out
);
   logic            valid_ff, valid_in;
   logic [4*WB-1:0] box_ff, box_in;
   logic            tok_ff;
   carry_type       carry_ff, carry_in_next;
   logic            enc_entry_n, enc_n_entry, rem, free_slot;
   logic signed [WB-1:0] el, et, er, eb, nl, nt, nr, nb;

   assign el = $signed(box_ff[WB-1:0]);
   assign et = $signed(box_ff[2*WB-1:WB]);
   assign er = $signed(box_ff[3*WB-1:2*WB]);
   assign eb = $signed(box_ff[4*WB-1:3*WB]);
   assign nl = $signed(nbox[WB-1:0]);
   assign nt = $signed(nbox[2*WB-1:WB]);
   assign nr = $signed(nbox[3*WB-1:2*WB]);
   assign nb = $signed(nbox[4*WB-1:3*WB]);

   assign enc_entry_n = (nl >= el) && (nt >= et) && (nr <= er) && (nb <= eb);
   assign enc_n_entry = (el >= nl) && (et >= nt) && (er <= nr) && (eb <= nb);
   assign rem         = valid_ff && enc_n_entry;
   assign free_slot   = !valid_ff || rem;

   always_comb begin
      valid_in      = valid_ff;
      box_in        = box_ff;
      carry_in_next = carry_in;
      if (clr) begin
         valid_in = 1'b0;
      end else if (tok_in) begin
         if (op == OP_CHECK) begin
            carry_in_next.found = carry_in.found | (valid_ff & enc_entry_n);
         end else begin
            if (rem) begin
               valid_in           = 1'b0;
               carry_in_next.nrem = carry_in.nrem + REM_W'(1);
            end
            if (free_slot && carry_in.pending) begin
               valid_in              = 1'b1;
               box_in                = nbox;
               carry_in_next.pending = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in;
      end
      box_ff   <= box_in;
      carry_ff <= carry_in_next;
   end

   assign tok_out   = tok_ff;
   assign carry_out = carry_ff;
endmodule

>>> src/dirty_rect_tracker.sv
// Dirty rectangle tracker top level.
// Items enter on req_ch (valid/ready): mode selects mark or clear of the table.
// A mark grows the rectangle by the radius, clips it to the bounds and runs it
// through a chain of MAX_RECTS slots, one slot per cycle: a first pass looks
// for a slot that already covers it; if none does, a second pass removes
// covered slots and writes it into the lowest free slot.
// Each item gives one summary item on rsp_ch: dirty flag, entry count, union
// of all entries and the sticky overflow flag.
// A mark runs both token passes over the slot chain, or only the first when a
// stored entry already covers it. A clear goes straight to the result, and an
// empty mark skips both passes.
// One item is in work at a time; req_ch.ready is high only when the block is
// idle and the result register is empty.
// A stalled receiver holds the result in the output register and the block
// takes no new item until it has been taken.
// Synchronous reset empties the table, zeroes the union, count, overflow flag
// and the configuration registers; no clearing pass is needed. The user writes
// configuration through csr_we/csr_index/csr_wdata only while idle (unenforced).
`include "dirty_rect_tracker_defines.svh"
module dirty_rect_tracker import drt_pkg::*; #(
   parameter int MAX_RECTS_P  = MAX_RECTS
) (
   input  logic                   clock,
   input  logic                   reset,
   drt_req_if.sink                req_ch,
   drt_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);
   localparam int WB    = ((COORD_BITS > 17) ? COORD_BITS : 17) + 2;
   localparam int CNT_W = $clog2(MAX_RECTS_P + 1);
   localparam logic signed [WB-1:0] COORD_HI = WB'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
   localparam logic signed [WB-1:0] COORD_LO = ~COORD_HI;

   function automatic logic signed [WB-1:0] clamp_c(input logic signed [WB-1:0] v);
      logic signed [WB-1:0] r;
      r = v;
      if (v < COORD_LO) r = COORD_LO;
      if (v > COORD_HI) r = COORD_HI;
      return r;
   endfunction

   state_type state_ff, state_in;
   logic [RADIUS_W-1:0]      radius_ff;
   logic signed [POS_W-1:0]  bx_ff, by_ff;
   logic [SIZE_W-1:0]        bw_ff, bh_ff;
   logic signed [POS_W-1:0]  in_x_ff, in_y_ff;
   logic [SIZE_W-1:0]        in_w_ff, in_h_ff;
   logic signed [WB-1:0]     e_l_ff, e_t_ff, e_r_ff, e_b_ff;
   logic signed [WB-1:0]     c_l, c_t, c_r, c_b, rad_s;
   logic [4*WB-1:0]          n_ff;
   logic                     empty;
   logic [CNT_W-1:0]         count_ff;
   logic signed [WB-1:0]     u_l_ff, u_t_ff, u_r_ff, u_b_ff;
   logic                     ovf_ff, rsp_valid_ff, start_ff, start_in;
   scan_op_type              op_ff;
   logic                     req_fire, rsp_fire, tok_last;
   logic [MAX_RECTS_P-1:0]   tok;
   carry_type                carry [MAX_RECTS_P];
   carry_type                carry_last, carry_seed;
   logic                     rsp_dirty_ff;
   logic [ENTRY_COUNT_W-1:0] rsp_count_ff;
   logic signed [POS_W-1:0]  rsp_x_ff, rsp_y_ff;
   logic [UNION_SIZE_W-1:0]  rsp_w_ff, rsp_h_ff;
   logic                     rsp_ovf_ff;
   logic signed [WB-1:0]     dw, dh;

   assign req_ch.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_fire     = rsp_valid_ff && rsp_ch.ready;
   assign tok_last     = tok[MAX_RECTS_P-1];
   assign carry_last   = carry[MAX_RECTS_P-1];
   assign carry_seed   = '{found: 1'b0, pending: 1'b1, nrem: '0};
   assign rad_s        = $signed({{(WB-RADIUS_W){1'b0}}, radius_ff});

   always_comb begin
      c_l = e_l_ff;
      c_t = e_t_ff;
      c_r = e_r_ff;
      c_b = e_b_ff;
      if (bw_ff != '0 && bh_ff != '0) begin
         if (WB'(bx_ff) > c_l) c_l = WB'(bx_ff);
         if (WB'(by_ff) > c_t) c_t = WB'(by_ff);
         if (WB'(bx_ff) + $signed({{(WB-SIZE_W){1'b0}}, bw_ff}) < c_r)
            c_r = WB'(bx_ff) + $signed({{(WB-SIZE_W){1'b0}}, bw_ff});
         if (WB'(by_ff) + $signed({{(WB-SIZE_W){1'b0}}, bh_ff}) < c_b)
            c_b = WB'(by_ff) + $signed({{(WB-SIZE_W){1'b0}}, bh_ff});
      end
      empty = (c_r <= c_l) || (c_b <= c_t);
   end

   genvar gi;
   generate
      for (gi = 0; gi < MAX_RECTS_P; gi++) begin : g_cell
         logic      tok_in_w;
         carry_type carry_in_w;
         if (gi == 0) begin : g_head
            assign tok_in_w   = start_ff;
            assign carry_in_w = carry_seed;
         end else begin : g_link
            assign tok_in_w   = tok[gi-1];
            assign carry_in_w = carry[gi-1];
         end
         drt_cell #(.WB(WB)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .clr       (req_fire && req_ch.mode == MODE_CLEAR),
            .op        (op_ff),
            .nbox      (n_ff),
            .tok_in    (tok_in_w),
            .carry_in  (carry_in_w),
            .tok_out   (tok[gi]),
            .carry_out (carry[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = (req_ch.mode == MODE_CLEAR) ? ST_FINISH : ST_EXPAND;
         end
         ST_EXPAND: state_in = ST_CLIP;
         ST_CLIP: state_in = empty ? ST_FINISH : ST_SCAN_CHECK;
         ST_SCAN_CHECK: begin
            if (tok_last) state_in = carry_last.found ? ST_FINISH : ST_SCAN_UPDATE;
         end
         ST_SCAN_UPDATE: begin
            if (tok_last) state_in = ST_FINISH;
         end
         ST_FINISH: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      start_in = 1'b0;
      unique case (state_ff)
         ST_CLIP: start_in = !empty;
         ST_SCAN_CHECK: start_in = tok_last && !carry_last.found;
         default: start_in = 1'b0;
      endcase
   end

   assign dw = u_r_ff - u_l_ff;
   assign dh = u_b_ff - u_t_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radius_ff    <= '0;
         bx_ff        <= '0;
         by_ff        <= '0;
         bw_ff        <= '0;
         bh_ff        <= '0;
         count_ff     <= '0;
         u_l_ff       <= '0;
         u_t_ff       <= '0;
         u_r_ff       <= '0;
         u_b_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         start_ff     <= 1'b0;
         op_ff        <= OP_CHECK;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_RADIUS:   radius_ff <= csr_wdata[RADIUS_W-1:0];
               CSR_BOUNDS_X: bx_ff     <= $signed(csr_wdata[POS_W-1:0]);
               CSR_BOUNDS_Y: by_ff     <= $signed(csr_wdata[POS_W-1:0]);
               CSR_BOUNDS_W: bw_ff     <= csr_wdata[SIZE_W-1:0];
               CSR_BOUNDS_H: bh_ff     <= csr_wdata[SIZE_W-1:0];
               default: ;
            endcase
         end
         if (req_fire && req_ch.mode == MODE_CLEAR) begin
            count_ff <= '0;
            u_l_ff   <= '0;
            u_t_ff   <= '0;
            u_r_ff   <= '0;
            u_b_ff   <= '0;
         end
         if (state_ff == ST_CLIP) op_ff <= OP_CHECK;
         if (state_ff == ST_SCAN_CHECK && tok_last) op_ff <= OP_UPDATE;
         if (state_ff == ST_SCAN_UPDATE && tok_last) begin
            if (carry_last.pending) begin
               ovf_ff <= 1'b1;
            end else begin
               count_ff <= count_ff - CNT_W'(carry_last.nrem) + CNT_W'(1);
               if (count_ff == '0 && carry_last.nrem == '0) begin
                  u_l_ff <= $signed(n_ff[WB-1:0]);
                  u_t_ff <= $signed(n_ff[2*WB-1:WB]);
                  u_r_ff <= $signed(n_ff[3*WB-1:2*WB]);
                  u_b_ff <= $signed(n_ff[4*WB-1:3*WB]);
               end else begin
                  if ($signed(n_ff[WB-1:0]) < u_l_ff) u_l_ff <= $signed(n_ff[WB-1:0]);
                  if ($signed(n_ff[2*WB-1:WB]) < u_t_ff) u_t_ff <= $signed(n_ff[2*WB-1:WB]);
                  if ($signed(n_ff[3*WB-1:2*WB]) > u_r_ff)
                     u_r_ff <= $signed(n_ff[3*WB-1:2*WB]);
                  if ($signed(n_ff[4*WB-1:3*WB]) > u_b_ff)
                     u_b_ff <= $signed(n_ff[4*WB-1:3*WB]);
               end
            end
         end
         if (state_ff == ST_FINISH) rsp_valid_ff <= 1'b1;
         else if (rsp_fire) rsp_valid_ff <= 1'b0;
      end
      if (req_fire) begin
         in_x_ff <= req_ch.rect_x;
         in_y_ff <= req_ch.rect_y;
         in_w_ff <= req_ch.rect_w;
         in_h_ff <= req_ch.rect_h;
      end
      if (state_ff == ST_EXPAND) begin
         e_l_ff <= clamp_c(WB'(in_x_ff) - rad_s);
         e_t_ff <= clamp_c(WB'(in_y_ff) - rad_s);
         e_r_ff <= clamp_c(WB'(in_x_ff) + $signed({{(WB-SIZE_W){1'b0}}, in_w_ff}) + rad_s);
         e_b_ff <= clamp_c(WB'(in_y_ff) + $signed({{(WB-SIZE_W){1'b0}}, in_h_ff}) + rad_s);
      end
      if (state_ff == ST_CLIP) n_ff <= {c_b, c_r, c_t, c_l};
      if (state_ff == ST_FINISH) begin
         rsp_dirty_ff <= (count_ff != '0);
         rsp_count_ff <= ENTRY_COUNT_W'(count_ff);
         rsp_ovf_ff   <= ovf_ff;
         if (count_ff != '0) begin
            rsp_x_ff <= u_l_ff[POS_W-1:0];
            rsp_y_ff <= u_t_ff[POS_W-1:0];
            rsp_w_ff <= dw[UNION_SIZE_W-1:0];
            rsp_h_ff <= dh[UNION_SIZE_W-1:0];
         end else begin
            rsp_x_ff <= '0;
            rsp_y_ff <= '0;
            rsp_w_ff <= '0;
            rsp_h_ff <= '0;
         end
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.is_dirty    = rsp_dirty_ff;
   assign rsp_ch.entry_count = rsp_count_ff;
   assign rsp_ch.union_x     = rsp_x_ff;
   assign rsp_ch.union_y     = rsp_y_ff;
   assign rsp_ch.union_w     = rsp_w_ff;
   assign rsp_ch.union_h     = rsp_h_ff;
   assign rsp_ch.overflowed  = rsp_ovf_ff;

   `DRT_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CNT_W'(MAX_RECTS_P))
   `DRT_ASSERT_NEXT(a_finish_gives_rsp, state_ff == ST_FINISH, rsp_valid_ff)
   `DRT_ASSERT_NEXT(a_accept_leaves_idle, req_fire, state_ff != ST_IDLE)
   `DRT_ASSERT_IMP(a_token_in_scan, tok_last,
                   state_ff == ST_SCAN_CHECK || state_ff == ST_SCAN_UPDATE)
endmodule

>>> bench/testbench.sv
// Self-checking testbench for the dirty rectangle tracker: directed and random items.
`timescale 1ns / 100ps
module testbench;
   import drt_pkg::*;

   localparam int COORD_LO  = -32768;
   localparam int COORD_HI  = 32767;
   localparam int IDLE_LIMIT = 20000;

   typedef struct {
      bit                        is_dirty;
      bit [ENTRY_COUNT_W-1:0]    entry_count;
      bit [POS_W-1:0]            union_x;
      bit [POS_W-1:0]            union_y;
      bit [UNION_SIZE_W-1:0]     union_w;
      bit [UNION_SIZE_W-1:0]     union_h;
      bit                        overflowed;
   } summary_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   drt_req_if req_ch ();
   drt_rsp_if rsp_ch ();

   dirty_rect_tracker dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Model of the table and its configuration.
   int  box_l[MAX_RECTS], box_t[MAX_RECTS], box_r[MAX_RECTS], box_b[MAX_RECTS];
   bit  box_used[MAX_RECTS];
   int  box_count;
   int  hull_l, hull_t, hull_r, hull_b;
   bit  dropped_flag;
   int  grow_radius;
   int  clip_x, clip_y, clip_w, clip_h;

   summary_type pending_summaries[$];
   int  error_count;
   int  idle_cycles;
   int  burst_left;
   int  stall_kind;
   int  stall_span;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic int clamp_coord(int v);
      return v < COORD_LO ? COORD_LO : (v > COORD_HI ? COORD_HI : v);
   endfunction

   function automatic void mark_box(int x, int y, int w, int h);
      int  l, t, r, b;
      bit  removed;
      l = clamp_coord(x - grow_radius);
      t = clamp_coord(y - grow_radius);
      r = clamp_coord(x + w + grow_radius);
      b = clamp_coord(y + h + grow_radius);
      removed = 1'b0;
      if (clip_w != 0 && clip_h != 0) begin
         if (clip_x > l) l = clip_x;
         if (clip_y > t) t = clip_y;
         if (clip_x + clip_w < r) r = clip_x + clip_w;
         if (clip_y + clip_h < b) b = clip_y + clip_h;
      end
      if (r <= l || b <= t) return;
      for (int i = 0; i < MAX_RECTS; i++)
         if (box_used[i] && l >= box_l[i] && t >= box_t[i] && r <= box_r[i] && b <= box_b[i])
            return;
      for (int i = 0; i < MAX_RECTS; i++)
         if (box_used[i] && box_l[i] >= l && box_t[i] >= t && box_r[i] <= r && box_b[i] <= b)
         begin
            box_used[i] = 1'b0;
            box_count--;
            removed = 1'b1;
         end
      if (!removed && box_count >= MAX_RECTS) begin
         dropped_flag = 1'b1;
         return;
      end
      for (int i = 0; i < MAX_RECTS; i++)
         if (!box_used[i]) begin
            box_used[i] = 1'b1;
            box_l[i] = l;
            box_t[i] = t;
            box_r[i] = r;
            box_b[i] = b;
            break;
         end
      if (box_count == 0 && !removed) begin
         hull_l = l;
         hull_t = t;
         hull_r = r;
         hull_b = b;
      end else begin
         if (l < hull_l) hull_l = l;
         if (t < hull_t) hull_t = t;
         if (r > hull_r) hull_r = r;
         if (b > hull_b) hull_b = b;
      end
      box_count++;
   endfunction

   function automatic summary_type apply_item(bit m, int x, int y, int w, int h);
      summary_type s;
      if (m == MODE_CLEAR) begin
         for (int i = 0; i < MAX_RECTS; i++) box_used[i] = 1'b0;
         box_count = 0;
      end else begin
         mark_box(x, y, w, h);
      end
      s.is_dirty    = box_count > 0;
      s.entry_count = box_count[ENTRY_COUNT_W-1:0];
      s.union_x     = box_count > 0 ? hull_l[POS_W-1:0] : '0;
      s.union_y     = box_count > 0 ? hull_t[POS_W-1:0] : '0;
      s.union_w     = box_count > 0 ? 16'(hull_r - hull_l) : '0;
      s.union_h     = box_count > 0 ? 16'(hull_b - hull_t) : '0;
      s.overflowed  = dropped_flag;
      return s;
   endfunction

   // Result checker.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_summaries.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual count %0d", $time,
                     rsp_ch.entry_count);
            error_count++;
         end else begin
            summary_type e;
            e = pending_summaries.pop_front();
            if (rsp_ch.is_dirty !== e.is_dirty) begin
               $display("%0t: is_dirty expected %0d actual %0d", $time, e.is_dirty,
                        rsp_ch.is_dirty);
               error_count++;
            end
            if (rsp_ch.entry_count !== e.entry_count) begin
               $display("%0t: entry_count expected %0d actual %0d", $time, e.entry_count,
                        rsp_ch.entry_count);
               error_count++;
            end
            if (rsp_ch.union_x !== e.union_x) begin
               $display("%0t: union_x expected %h actual %h", $time, e.union_x, rsp_ch.union_x);
               error_count++;
            end
            if (rsp_ch.union_y !== e.union_y) begin
               $display("%0t: union_y expected %h actual %h", $time, e.union_y, rsp_ch.union_y);
               error_count++;
            end
            if (rsp_ch.union_w !== e.union_w) begin
               $display("%0t: union_w expected %h actual %h", $time, e.union_w, rsp_ch.union_w);
               error_count++;
            end
            if (rsp_ch.union_h !== e.union_h) begin
               $display("%0t: union_h expected %h actual %h", $time, e.union_h, rsp_ch.union_h);
               error_count++;
            end
            if (rsp_ch.overflowed !== e.overflowed) begin
               $display("%0t: overflowed expected %0d actual %0d", $time, e.overflowed,
                        rsp_ch.overflowed);
               error_count++;
            end
         end
      end
   end

   // Receiver stalls in phases of varying density.
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_kind = $urandom_range(0, 2);
         stall_span = $urandom_range(50, 400);
      end
      stall_span--;
      case (stall_kind)
         0: begin
            rsp_ch.ready <= 1'b1;
         end
         1: begin
            rsp_ch.ready <= 1'($urandom_range(0, 1));
         end
         default: begin
            rsp_ch.ready <= ($urandom_range(0, 4) == 0);
         end
      endcase
   end

   // Watchdog on cycles without any accepted item.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic send_item(bit m, int x, int y, int w, int h);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 10);
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid  <= 1'b1;
      req_ch.mode   <= m;
      req_ch.rect_x <= x[POS_W-1:0];
      req_ch.rect_y <= y[POS_W-1:0];
      req_ch.rect_w <= w[SIZE_W-1:0];
      req_ch.rect_h <= h[SIZE_W-1:0];
      do @(posedge clock); while (!req_ch.ready);
      pending_summaries.push_back(apply_item(m, x, y, w, h));
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_summaries.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_RADIUS:   grow_radius = value & 8'hFF;
         CSR_BOUNDS_X: clip_x = $signed(value[15:0]);
         CSR_BOUNDS_Y: clip_y = $signed(value[15:0]);
         CSR_BOUNDS_W: clip_w = value & 15'h7FFF;
         default:      clip_h = value & 15'h7FFF;
      endcase
   endtask

   task automatic configure(int rad, int bx, int by, int bw, int bh);
      drain();
      write_csr(CSR_RADIUS, rad);
      write_csr(CSR_BOUNDS_X, bx);
      write_csr(CSR_BOUNDS_Y, by);
      write_csr(CSR_BOUNDS_W, bw);
      write_csr(CSR_BOUNDS_H, bh);
   endtask

   task automatic test_directed();
      send_item(MODE_MARK, 10, 10, 5, 5);
      send_item(MODE_MARK, 11, 11, 2, 2);
      send_item(MODE_MARK, 0, 0, 40, 40);
      send_item(MODE_MARK, 100, 100, 0, 7);
      send_item(MODE_MARK, 100, 100, 7, 0);
      send_item(MODE_MARK, COORD_LO, COORD_LO, 32767, 32767);
      send_item(MODE_MARK, COORD_HI, COORD_HI, 32767, 32767);
      send_item(MODE_CLEAR, -1, -1, 32767, 32767);
      send_item(MODE_MARK, COORD_HI, COORD_LO, 1, 1);
      configure(255, 0, 0, 0, 0);
      send_item(MODE_MARK, COORD_LO, COORD_HI, 32767, 0);
      send_item(MODE_MARK, 0, 0, 0, 0);
      send_item(MODE_MARK, COORD_HI, COORD_HI, 32767, 32767);
      configure(3, -20, -20, 50, 60);
      send_item(MODE_MARK, -100, -100, 300, 300);
      send_item(MODE_MARK, 200, 200, 5, 5);
      send_item(MODE_MARK, 28, 38, 1, 1);
      send_item(MODE_CLEAR, 0, 0, 0, 0);
      configure(0, COORD_LO, COORD_LO, 32767, 32767);
      send_item(MODE_MARK, COORD_LO, COORD_LO, 32767, 32767);
      send_item(MODE_MARK, 5, 5, 32767, 32767);
      send_item(MODE_CLEAR, 0, 0, 0, 0);
   endtask

   task automatic test_table_full();
      configure(0, 0, 0, 0, 0);
      for (int i = 0; i < MAX_RECTS + 4; i++)
         send_item(MODE_MARK, (i % 16) * 4, (i / 16) * 4, 2, 2);
      send_item(MODE_MARK, -1, -1, 10, 10);
      send_item(MODE_MARK, 200, 200, 3, 3);
      send_item(MODE_CLEAR, 0, 0, 0, 0);
      send_item(MODE_MARK, 1, 1, 1, 1);
   endtask

   task automatic send_random(int count);
      int x, y, w, h, k;
      for (int n = 0; n < count; n++) begin
         k = $urandom_range(0, 99);
         if (k < 4) begin
            send_item(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom);
         end else if (k < 74) begin
            x = $urandom_range(0, 160) - 80;
            y = $urandom_range(0, 160) - 80;
            w = $urandom_range(0, 40);
            h = $urandom_range(0, 40);
            send_item(MODE_MARK, x, y, w, h);
         end else if (k < 90) begin
            send_item(MODE_MARK, $signed(16'($urandom)), $signed(16'($urandom)),
                      $urandom_range(0, 32767), $urandom_range(0, 32767));
         end else begin
            x = $urandom_range(0, 1) ? COORD_HI - $urandom_range(0, 300)
                                     : COORD_LO + $urandom_range(0, 300);
            y = $urandom_range(0, 1) ? COORD_HI - $urandom_range(0, 300)
                                     : COORD_LO + $urandom_range(0, 300);
            send_item(MODE_MARK, x, y, $urandom_range(0, 500), $urandom_range(0, 500));
         end
      end
   endtask

   task automatic test_random();
      configure(0, 0, 0, 0, 0);
      send_random(180);
      configure(255, COORD_LO, COORD_LO, 32767, 32767);
      send_random(160);
      configure($urandom_range(1, 20), -50, -40, 100, 90);
      send_random(180);
      configure($urandom_range(0, 255), $signed(16'($urandom)), $signed(16'($urandom)),
                $urandom_range(0, 32767), 0);
      send_random(140);
      configure(255, COORD_HI, COORD_HI, 32767, 32767);
      send_random(100);
      configure($urandom_range(0, 8), $urandom_range(0, 60) - 30, $urandom_range(0, 60) - 30,
                $urandom_range(1, 200), $urandom_range(1, 200));
      send_random(160);
   endtask

   initial begin
      error_count = 0;
      burst_left  = 0;
      stall_span  = 0;
      stall_kind  = 0;
      idle_cycles = 0;
      for (int i = 0; i < MAX_RECTS; i++) box_used[i] = 1'b0;
      box_count    = 0;
      hull_l       = 0;
      hull_t       = 0;
      hull_r       = 0;
      hull_b       = 0;
      dropped_flag = 1'b0;
      grow_radius  = 0;
      clip_x       = 0;
      clip_y       = 0;
      clip_w       = 0;
      clip_h       = 0;
      reset         <= 1'b1;
      csr_we        <= 1'b0;
      csr_index     <= CSR_RADIUS;
      csr_wdata     <= '0;
      req_ch.valid  <= 1'b0;
      req_ch.mode   <= MODE_MARK;
      req_ch.rect_x <= '0;
      req_ch.rect_y <= '0;
      req_ch.rect_w <= '0;
      req_ch.rect_h <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_table_full();
      test_random();
      drain();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

>>> files.f
+incdir+src
src/drt_pkg.sv
src/drt_req_if.sv
src/drt_rsp_if.sv
src/drt_cell.sv
src/dirty_rect_tracker.sv
bench/testbench.sv
